// ===== design/lmsu_pkg.sv =====
// Shared types and constants for the linear model score and update block.
`timescale 1ns / 1ps
`default_nettype none
package lmsu_pkg;

  localparam int NUM_WEIGHTS = 1024;
  localparam int ADDR_W      = $clog2(NUM_WEIGHTS);
  localparam int CNT_W       = $clog2(NUM_WEIGHTS + 1);

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int SCORE_W = 48;
  localparam int CFG_W   = 16;

  localparam logic [CFG_W-1:0] RATE_RESET = 16'd655;
  localparam logic [CFG_W-1:0] REG_RESET  = 16'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCORE  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_RATE = 1'b0,
    CFG_REG  = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROD,
    ST_DIFF,
    ST_SCALE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] reward;
    logic                    last;
  } req_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      saturated;
  } rsp_t;

  typedef struct packed {
    logic prod_en;
    logic diff_en;
    logic scale_en;
    logic update;
  } arith_ctl_t;

endpackage
`default_nettype wire

// ===== design/lmsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lmsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/lmsu_arith.sv =====
// Multiply, scale and saturate datapath for score and weight update.
`timescale 1ns / 1ps
`default_nettype none
module lmsu_arith
  import lmsu_pkg::*;
(
  input  logic                      clk_i,
  input  arith_ctl_t                ctl_i,
  input  logic signed [VAL_W-1:0]   value_i,
  input  logic signed [VAL_W-1:0]   reward_i,
  input  logic signed [VAL_W-1:0]   weight_i,
  input  logic [CFG_W-1:0]          rate_i,
  input  logic [CFG_W-1:0]          reg_i,
  input  logic signed [SCORE_W-1:0] sum_i,
  output logic signed [SCORE_W-1:0] sum_o,
  output logic                      sum_sat_o,
  output logic signed [VAL_W-1:0]   weight_o,
  output logic                      weight_sat_o
);

  // Product stage
  logic signed [2*VAL_W-1:0]     prod_a_d, prod_a_q;
  logic signed [VAL_W+CFG_W:0]   prod_b_d, prod_b_q;
  logic signed [VAL_W-1:0]       mul_b;
  logic signed [VAL_W-1:0]       w_q;
  // Difference stage
  logic signed [SCORE_W:0]       diff_d, diff_q;
  // Scale stage: rate times the upper and lower parts of the difference
  logic signed [SCORE_W+1:0]     scale_hi_d, scale_hi_q;
  logic [2*CFG_W-1:0]            scale_lo_d, scale_lo_q;
  // Finish
  logic signed [SCORE_W+2:0]     nw_full;
  logic signed [SCORE_W:0]       sum_full;

  assign mul_b    = ctl_i.update ? reward_i : weight_i;
  assign prod_a_d = value_i * mul_b;
  assign prod_b_d = $signed({1'b0, reg_i}) * weight_i;

  assign diff_d = $signed(prod_a_q[2*VAL_W-1:16]) - $signed(prod_b_q[VAL_W+CFG_W:16]);

  assign scale_hi_d = $signed({1'b0, rate_i}) * $signed(diff_q[SCORE_W:16]);
  assign scale_lo_d = rate_i * diff_q[15:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
      w_q      <= weight_i;
    end
    if (ctl_i.diff_en) begin
      diff_q <= diff_d;
    end
    if (ctl_i.scale_en) begin
      scale_hi_q <= scale_hi_d;
      scale_lo_q <= scale_lo_d;
    end
  end

  // Floor of rate*d/2^16 = rate*d_hi + floor(rate*d_lo/2^16), d_lo non-negative
  assign nw_full = w_q + scale_hi_q + $signed({1'b0, scale_lo_q[2*CFG_W-1:16]});

  always_comb begin
    weight_sat_o = 1'b0;
    weight_o     = nw_full[VAL_W-1:0];
    if (!nw_full[SCORE_W+2] && (|nw_full[SCORE_W+1:VAL_W-1])) begin
      weight_sat_o = 1'b1;
      weight_o     = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (nw_full[SCORE_W+2] && !(&nw_full[SCORE_W+1:VAL_W-1])) begin
      weight_sat_o = 1'b1;
      weight_o     = {1'b1, {(VAL_W-1){1'b0}}};
    end
  end

  assign sum_full = sum_i + $signed(prod_a_q[2*VAL_W-1:16]);

  always_comb begin
    sum_sat_o = 1'b0;
    sum_o     = sum_full[SCORE_W-1:0];
    if (sum_full[SCORE_W] != sum_full[SCORE_W-1]) begin
      sum_sat_o = 1'b1;
      sum_o     = sum_full[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                    : {1'b0, {(SCORE_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ===== design/linear_model_score_and_update.sv =====
// Top level: weight memory, command sequencer and result register.
//
// Linear model with 1024 signed Q16.16 weights in one RAM (one write and one
// registered read port). One request is in flight at a time: a score request
// steps through read, multiply and accumulate, an update request through read,
// two products, difference, rate scaling and write back, and an unused
// command is taken without any step. A clear request, and reset itself, run
// a sweep that writes zero to all 1024 weights, during which in_stall_o is
// high; configuration writes are taken at any time. A new request is taken
// while a finished result still sits in the output register; a last request
// holds in its final step until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module linear_model_score_and_update
  import lmsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o
);

  state_e                    state_q, state_d;
  logic [ADDR_W-1:0]         clr_cnt_q, clr_cnt_d;
  req_t                      req_q;
  logic [CFG_W-1:0]          rate_q, reg_q;
  logic [CNT_W-1:0]          active_q, active_d;
  logic signed [SCORE_W-1:0] sum_q, sum_d;
  logic                      sat_q, sat_d;
  logic                      out_valid_q, out_valid_d;
  rsp_t                      out_rsp_q, out_rsp_d;

  logic                      in_accept;
  logic                      out_free;
  logic                      in_range;
  logic                      hit;
  logic                      is_update;
  arith_ctl_t                ctl;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [VAL_W-1:0]          ram_wdata;
  logic [VAL_W-1:0]          ram_rdata;
  logic signed [VAL_W-1:0]   weight_rd;

  logic signed [SCORE_W-1:0] arith_sum;
  logic                      arith_sum_sat;
  logic signed [VAL_W-1:0]   arith_weight;
  logic                      arith_weight_sat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_range  = 32'(req_q.index) < NUM_WEIGHTS;
  assign hit       = 32'(req_q.index) < 32'(active_q);
  assign is_update = (cmd_e'(req_q.command) == CMD_UPDATE);
  assign weight_rd = in_range ? $signed(ram_rdata) : '0;

  lmsu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_WEIGHTS)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (ADDR_W'(in_req_i.index)),
    .rdata_o (ram_rdata)
  );

  lmsu_arith u_arith (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .value_i      (req_q.value),
    .reward_i     (req_q.reward),
    .weight_i     (weight_rd),
    .rate_i       (rate_q),
    .reg_i        (reg_q),
    .sum_i        (sum_q),
    .sum_o        (arith_sum),
    .sum_sat_o    (arith_sum_sat),
    .weight_o     (arith_weight),
    .weight_sat_o (arith_weight_sat)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    active_d    = active_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    ctl         = '0;
    ctl.update  = is_update;
    ram_we      = 1'b0;
    ram_waddr   = ADDR_W'(req_q.index);
    ram_wdata   = arith_weight;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(NUM_WEIGHTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd_e'(in_req_i.command))
            CMD_SCORE, CMD_UPDATE: state_d = ST_PROD;
            CMD_CLEAR: begin
              state_d   = ST_CLEAR;
              clr_cnt_d = '0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PROD: begin
        ctl.prod_en = 1'b1;
        state_d     = is_update ? ST_DIFF : ST_FINISH;
      end
      ST_DIFF: begin
        ctl.diff_en = 1'b1;
        state_d     = ST_SCALE;
      end
      ST_SCALE: begin
        ctl.scale_en = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold a last request until the result register can take it
        if (!req_q.last || out_free) begin
          state_d = ST_IDLE;
          if (is_update) begin
            ram_we = in_range;
            sat_d  = sat_q || (in_range && arith_weight_sat);
            if (req_q.last) begin
              active_d = (32'(req_q.index) + 1 > NUM_WEIGHTS) ? CNT_W'(NUM_WEIGHTS)
                                                               : CNT_W'(32'(req_q.index) + 1);
            end
          end else if (hit) begin
            sum_d = arith_sum;
            sat_d = sat_q || arith_sum_sat;
          end
          if (req_q.last) begin
            out_valid_d         = 1'b1;
            out_rsp_d.score     = is_update ? '0 : sum_d;
            out_rsp_d.saturated = sat_d;
            sum_d               = '0;
            sat_d               = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      active_q    <= '0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      active_q    <= active_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
      reg_q  <= REG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_RATE: rate_q <= cfg_data_i;
        CFG_REG:  reg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
`default_nettype wire
